/* hdl/atp_pkg.sv */
package atp_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int ANGLE_FRAC_BITS = 13;

  localparam int QF      = 16;
  localparam int CW      = COORD_WIDTH;
  localparam int NUM_W   = CW + QF;
  localparam int QUO_W   = QF + 1;
  localparam int S_W     = QF + 1;
  localparam int T_W     = QF + 1;
  localparam int PROD_W  = 2 * QF + 4;
  localparam int R_W     = QF + 4;
  localparam int ANGLE_W = 16;

  localparam int PREP_ST  = 2;
  localparam int POLY_ST  = 10;
  localparam int FOLD_ST  = 2;
  localparam int PIPE_LAT = PREP_ST + QUO_W + POLY_ST + FOLD_ST;

  localparam int SH_R  = (ANGLE_FRAC_BITS < QF) ? QF - ANGLE_FRAC_BITS : 1;
  localparam int SH_L  = (ANGLE_FRAC_BITS > QF) ? ANGLE_FRAC_BITS - QF : 0;
  localparam int RES_W = R_W + SH_L;

  localparam logic signed [T_W-1:0]    C3_Q      = T_W'(3047);
  localparam logic signed [T_W-1:0]    C2_Q      = T_W'(10441);
  localparam logic signed [T_W-1:0]    C1_Q      = T_W'(21471);
  localparam logic signed [T_W-1:0]    NEG_C3_Q  = -C3_Q;
  localparam logic signed [R_W-1:0]    HALF_PI_Q = R_W'(102944);
  localparam logic signed [R_W-1:0]    PI_Q      = R_W'(205887);
  localparam logic signed [PROD_W-1:0] RND_HALF  = PROD_W'(1) <<< (QF - 1);
  localparam logic signed [RES_W-1:0]  RND_OUT   = RES_W'(1) <<< (SH_R - 1);

  typedef struct packed {
    logic zero;
    logic swap;
    logic xneg;
    logic yneg;
  } meta_t;

  // round to nearest, ties toward plus infinity
  function automatic logic signed [PROD_W-1:0] rnd_q(input logic signed [PROD_W-1:0] v);
    return (v + RND_HALF) >>> QF;
  endfunction

endpackage

/* hdl/atp_prep.sv */
module atp_prep (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic signed [atp_pkg::CW-1:0] x_in,
  input  logic signed [atp_pkg::CW-1:0] y_in,
  output logic                         out_vld,
  output atp_pkg::meta_t               meta_out,
  output logic [atp_pkg::NUM_W-1:0]    num_out,
  output logic [atp_pkg::CW-1:0]       den_out
);
  import atp_pkg::*;

  logic          vld_a_r;
  meta_t         meta_a_r;
  logic [CW-1:0] ax_r, ay_r;
  logic [CW-1:0] ax_nxt, ay_nxt;

  logic             vld_b_r;
  meta_t            meta_b_r;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [CW-1:0]    den_r, den_nxt;
  logic [CW-1:0]    mn;
  logic             swap;

  // magnitudes, most negative input wraps to its exact unsigned magnitude
  always_comb begin
    ax_nxt = x_in[CW-1] ? CW'(-x_in) : CW'(x_in);
    ay_nxt = y_in[CW-1] ? CW'(-y_in) : CW'(y_in);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else begin
      vld_a_r <= in_vld;
    end
    ax_r          <= ax_nxt;
    ay_r          <= ay_nxt;
    meta_a_r.zero <= (x_in == '0) && (y_in == '0);
    meta_a_r.swap <= 1'b0;
    meta_a_r.xneg <= x_in[CW-1];
    meta_a_r.yneg <= y_in[CW-1];
  end

  always_comb begin
    swap    = ay_r > ax_r;
    mn      = swap ? ax_r : ay_r;
    den_nxt = swap ? ay_r : ax_r;
    num_nxt = {mn, QF'(0)} + NUM_W'(den_nxt >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else begin
      vld_b_r <= vld_a_r;
    end
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    meta_b_r <= {meta_a_r.zero, swap, meta_a_r.xneg, meta_a_r.yneg};
  end

  assign out_vld  = vld_b_r;
  assign meta_out = meta_b_r;
  assign num_out  = num_r;
  assign den_out  = den_r;

endmodule

/* hdl/atp_div.sv */
module atp_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  atp_pkg::meta_t            meta_in,
  input  logic [atp_pkg::NUM_W-1:0] num_in,
  input  logic [atp_pkg::CW-1:0]    den_in,
  output logic                      out_vld,
  output atp_pkg::meta_t            meta_out,
  output logic [atp_pkg::QUO_W-1:0] quo_out
);
  import atp_pkg::*;

  logic             vld_r  [0:QUO_W-1];
  meta_t            meta_r [0:QUO_W-1];
  logic [QUO_W-1:0] quo_r  [0:QUO_W-1];
  logic [NUM_W-1:0] rem_r  [0:QUO_W-2];
  logic [CW-1:0]    den_r  [0:QUO_W-2];

  // restoring division, one quotient bit per stage, msb first
  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    localparam int BIT = QUO_W - 1 - k;

    logic             vld_i;
    meta_t            meta_i;
    logic [QUO_W-1:0] quo_i;
    logic [NUM_W-1:0] rem_i;
    logic [CW-1:0]    den_i;
    logic [NUM_W-1:0] dsh;
    logic             ge;
    logic [QUO_W-1:0] quo_nxt;
    logic [NUM_W-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign vld_i  = in_vld;
      assign meta_i = meta_in;
      assign quo_i  = '0;
      assign rem_i  = num_in;
      assign den_i  = den_in;
    end else begin : g_next
      assign vld_i  = vld_r[k-1];
      assign meta_i = meta_r[k-1];
      assign quo_i  = quo_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign den_i  = den_r[k-1];
    end

    always_comb begin
      dsh          = NUM_W'(den_i) << BIT;
      ge           = rem_i >= dsh;
      rem_nxt      = ge ? rem_i - dsh : rem_i;
      quo_nxt      = quo_i;
      quo_nxt[BIT] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_i;
      end
      meta_r[k] <= meta_i;
      quo_r[k]  <= quo_nxt;
    end

    if (k < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_i;
      end
    end
  end

  assign out_vld  = vld_r[QUO_W-1];
  assign meta_out = meta_r[QUO_W-1];
  assign quo_out  = quo_r[QUO_W-1];

endmodule

/* hdl/atp_poly.sv */
module atp_poly (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  atp_pkg::meta_t                 meta_in,
  input  logic [atp_pkg::QUO_W-1:0]      a_in,
  output logic                           out_vld,
  output atp_pkg::meta_t                 meta_out,
  output logic signed [atp_pkg::R_W-1:0] r_out
);
  import atp_pkg::*;

  logic             vld_r  [0:POLY_ST-1];
  meta_t            meta_r [0:POLY_ST-1];
  logic [QUO_W-1:0] a_dl_r [0:8];
  logic [S_W-1:0]   s_dl_r [1:5];

  logic [2*QUO_W-1:0]       sq_r, sq_nxt;
  logic [S_W-1:0]           s_nxt;
  logic signed [PROD_W-1:0] p1_r, p1_nxt, p2_r, p2_nxt, p3_r, p3_nxt, p4_r, p4_nxt;
  logic signed [T_W-1:0]    t1_r, t1_nxt, t2_r, t2_nxt, t3_r, t3_nxt;
  logic signed [R_W-1:0]    r_r, r_nxt;
  logic signed [S_W:0]      s3_sg, s5_sg;
  logic signed [QUO_W:0]    a7_sg, a8_sg;

  always_comb begin
    s3_sg  = signed'({1'b0, s_dl_r[3]});
    s5_sg  = signed'({1'b0, s_dl_r[5]});
    a7_sg  = signed'({1'b0, a_dl_r[7]});
    a8_sg  = signed'({1'b0, a_dl_r[8]});
    sq_nxt = a_in * a_in;
    s_nxt  = S_W'(rnd_q(signed'(PROD_W'(sq_r))));
    p1_nxt = NEG_C3_Q * signed'({1'b0, s_dl_r[1]});
    t1_nxt = T_W'(rnd_q(p1_r)) + C2_Q;
    p2_nxt = t1_r * s3_sg;
    t2_nxt = T_W'(rnd_q(p2_r)) - C1_Q;
    p3_nxt = t2_r * s5_sg;
    t3_nxt = T_W'(rnd_q(p3_r));
    p4_nxt = t3_r * a7_sg;
    r_nxt  = R_W'(rnd_q(p4_r)) + R_W'(a8_sg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < POLY_ST; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < POLY_ST; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
    meta_r[0] <= meta_in;
    for (int k = 1; k < POLY_ST; k++) begin
      meta_r[k] <= meta_r[k-1];
    end
    a_dl_r[0] <= a_in;
    for (int k = 1; k < 9; k++) begin
      a_dl_r[k] <= a_dl_r[k-1];
    end
    s_dl_r[1] <= s_nxt;
    for (int k = 2; k < 6; k++) begin
      s_dl_r[k] <= s_dl_r[k-1];
    end
    sq_r <= sq_nxt;
    p1_r <= p1_nxt;
    t1_r <= t1_nxt;
    p2_r <= p2_nxt;
    t2_r <= t2_nxt;
    p3_r <= p3_nxt;
    t3_r <= t3_nxt;
    p4_r <= p4_nxt;
    r_r  <= r_nxt;
  end

  assign out_vld  = vld_r[POLY_ST-1];
  assign meta_out = meta_r[POLY_ST-1];
  assign r_out    = r_r;

endmodule

/* hdl/atp_fold.sv */
module atp_fold (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_vld,
  input  atp_pkg::meta_t                     meta_in,
  input  logic signed [atp_pkg::R_W-1:0]     r_in,
  output logic                               out_vld,
  output logic signed [atp_pkg::ANGLE_W-1:0] angle_out
);
  import atp_pkg::*;

  logic                  vld_a_r;
  meta_t                 meta_a_r;
  logic signed [R_W-1:0] r1, r2_nxt, r2_r, r3;

  logic                      vld_b_r;
  logic signed [RES_W-1:0]   res;
  logic signed [ANGLE_W-1:0] angle_r, angle_nxt;

  // octant folds
  always_comb begin
    r1     = meta_in.swap ? HALF_PI_Q - r_in : r_in;
    r2_nxt = meta_in.xneg ? PI_Q - r1 : r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else begin
      vld_a_r <= in_vld;
    end
    meta_a_r <= meta_in;
    r2_r     <= r2_nxt;
  end

  // sign fold and scaling to the output format
  always_comb begin
    r3 = meta_a_r.yneg ? -r2_r : r2_r;
    if (ANGLE_FRAC_BITS < QF) begin
      res = (RES_W'(r3) + RND_OUT) >>> SH_R;
    end else begin
      res = RES_W'(r3) <<< SH_L;
    end
    angle_nxt = meta_a_r.zero ? '0 : res[ANGLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else begin
      vld_b_r <= vld_a_r;
    end
    angle_r <= angle_nxt;
  end

  assign out_vld   = vld_b_r;
  assign angle_out = angle_r;

endmodule

/* hdl/atan2_polynomial.sv */
// Four-quadrant arctangent of (in_x_coord, in_y_coord), given as a Q3.13 radian angle
// from -pi to pi on out_angle. A transaction is taken on every clock with start high;
// busy stays low, so a new vector can be presented each cycle. The result shows up
// with a one-cycle out_valid strobe after 2 prep stages, one stage per quotient bit
// of the 17-stage restoring divider, 10 polynomial stages and 2 fold stages. The
// receiver cannot stall the block and must take each result when strobed.
// Both coordinates zero give an angle of zero.
module atan2_polynomial (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [atp_pkg::CW-1:0]       in_x_coord,
  input  logic signed [atp_pkg::CW-1:0]       in_y_coord,
  output logic                                out_valid,
  output logic signed [atp_pkg::ANGLE_W-1:0]  out_angle
);
  import atp_pkg::*;

  logic             acc;
  logic             prep_vld, div_vld, poly_vld;
  meta_t            prep_meta, div_meta, poly_meta;
  logic [NUM_W-1:0] prep_num;
  logic [CW-1:0]    prep_den;
  logic [QUO_W-1:0] div_quo;
  logic signed [R_W-1:0] poly_r;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  atp_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (acc),
    .x_in     (in_x_coord),
    .y_in     (in_y_coord),
    .out_vld  (prep_vld),
    .meta_out (prep_meta),
    .num_out  (prep_num),
    .den_out  (prep_den)
  );

  atp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (prep_vld),
    .meta_in  (prep_meta),
    .num_in   (prep_num),
    .den_in   (prep_den),
    .out_vld  (div_vld),
    .meta_out (div_meta),
    .quo_out  (div_quo)
  );

  atp_poly u_poly (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (div_vld),
    .meta_in  (div_meta),
    .a_in     (div_quo),
    .out_vld  (poly_vld),
    .meta_out (poly_meta),
    .r_out    (poly_r)
  );

  atp_fold u_fold (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (poly_vld),
    .meta_in   (poly_meta),
    .r_in      (poly_r),
    .out_vld   (out_valid),
    .angle_out (out_angle)
  );

  // every result strobe traces back to an accepted transaction
  a_strobe_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, PIPE_LAT))
    else $error("result strobe without matching transaction");

  // origin vector gives zero
  a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_x_coord == '0 && in_y_coord == '0)
      |-> ##PIPE_LAT (out_valid && out_angle == '0))
    else $error("origin vector did not give zero angle");

  // positive horizontal axis gives zero
  a_xaxis_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_y_coord == '0 && !in_x_coord[CW-1] && in_x_coord != '0)
      |-> ##PIPE_LAT (out_valid && out_angle == '0))
    else $error("positive x axis did not give zero angle");

endmodule
